// ===== design/tod_pkg.sv =====
// Shared types and constants for the time-of-day clock.
// No dependencies; imported by every module of the block.
package tod_pkg;

  localparam int unsigned MsWidth     = 32;
  localparam int unsigned PeriodWidth = 16;
  localparam int unsigned HourWidth   = 5;
  localparam int unsigned MinWidth    = 6;
  localparam int unsigned SecWidth    = 6;

  localparam logic [HourWidth-1:0]   HoursPerDay   = 5'd24;
  localparam logic [MinWidth-1:0]    MinsPerHour   = 6'd60;
  localparam logic [SecWidth-1:0]    SecsPerMin    = 6'd60;
  localparam logic [PeriodWidth-1:0] PeriodDefault = 16'd1000;

  // One polling request as held in the input register.
  typedef struct packed {
    logic [MsWidth-1:0] now_ms;
    logic               minute_button_level;
    logic               hour_button_level;
    logic               second_button_level;
  } tod_item_t;

  // One result item.
  typedef struct packed {
    logic [HourWidth-1:0] hours;
    logic [MinWidth-1:0]  minutes;
    logic [SecWidth-1:0]  seconds;
    logic                 dot_on;
    logic                 display_update;
  } tod_result_t;

endpackage

// ===== design/tod_in_stage.sv =====
// Input register of the time-of-day clock: captures one request per cycle while in_stall is low.
// Depends on tod_pkg; feeds tod_core.
module tod_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tod_pkg::tod_item_t in_item,
  input  logic               advance,
  output logic               item_valid,
  output tod_pkg::tod_item_t item
);
  import tod_pkg::*;

  // Hold the registered request while the core cannot take it.
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ===== design/tod_core.sv =====
// Time keeping core: hh:mm:ss counters, dot flag, button edge tracking and
// the result register. Depends on tod_pkg; driven by tod_in_stage.
module tod_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [tod_pkg::PeriodWidth-1:0]      tick_period_ms,
  input  logic                                 item_valid,
  input  tod_pkg::tod_item_t                   item,
  output logic                                 advance,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tod_pkg::tod_result_t                 result
);
  import tod_pkg::*;

  logic [HourWidth-1:0] hour_count, hour_count_next;
  logic [MinWidth-1:0]  minute_count, minute_count_next;
  logic [SecWidth-1:0]  second_count, second_count_next;
  logic                 dot_flag, dot_flag_next;
  logic                 minute_button_high, minute_button_high_next;
  logic                 hour_button_high, hour_button_high_next;
  logic                 second_button_high, second_button_high_next;
  logic [MsWidth-1:0]   last_second_ms, last_second_ms_next;
  logic                 update_next;
  logic                 fire;
  logic [MsWidth-1:0]   half_at;
  logic [MsWidth-1:0]   full_at;

  assign advance = !out_valid || !out_stall;
  assign fire    = item_valid && advance;

  // Compare points wrap at 2^32 like the millisecond counter.
  assign half_at = last_second_ms + {{(MsWidth-PeriodWidth+1){1'b0}},
                                     tick_period_ms[PeriodWidth-1:1]};
  assign full_at = last_second_ms + {{(MsWidth-PeriodWidth){1'b0}}, tick_period_ms};

  always_comb begin
    logic tick;
    logic min_carry;
    logic mfall, hfall, sfall;
    hour_count_next         = hour_count;
    minute_count_next       = minute_count;
    second_count_next       = second_count;
    dot_flag_next           = dot_flag;
    minute_button_high_next = minute_button_high;
    hour_button_high_next   = hour_button_high;
    second_button_high_next = second_button_high;
    last_second_ms_next     = last_second_ms;
    update_next             = 1'b0;
    tick      = 1'b0;
    min_carry = 1'b0;
    mfall     = 1'b0;
    hfall     = 1'b0;
    sfall     = 1'b0;

    if (!dot_flag && (item.now_ms > half_at)) begin
      dot_flag_next = 1'b1;
      update_next   = 1'b1;
    end

    // Advance one second with carry.
    if (item.now_ms > full_at) begin
      tick                = 1'b1;
      update_next         = 1'b1;
      dot_flag_next       = 1'b0;
      last_second_ms_next = item.now_ms;
      if (second_count + 6'd1 >= SecsPerMin) begin
        second_count_next = '0;
        min_carry         = 1'b1;
      end else begin
        second_count_next = second_count + 6'd1;
      end
    end

    if (tick && min_carry) begin
      if (minute_count + 6'd1 >= MinsPerHour) begin
        minute_count_next = '0;
        hour_count_next   = (hour_count + 5'd1 >= HoursPerDay) ? '0 : hour_count + 5'd1;
      end else begin
        minute_count_next = minute_count + 6'd1;
      end
    end

    // First falling edge in priority order wins; later buttons are left alone.
    mfall = minute_button_high && !item.minute_button_level;
    if (mfall) begin
      minute_button_high_next = 1'b0;
      update_next             = 1'b1;
      if (minute_count_next + 6'd1 >= MinsPerHour) begin
        minute_count_next = '0;
        hour_count_next   = (hour_count_next + 5'd1 >= HoursPerDay) ? '0 :
                            hour_count_next + 5'd1;
      end else begin
        minute_count_next = minute_count_next + 6'd1;
      end
    end else begin
      if (!minute_button_high && item.minute_button_level) begin
        minute_button_high_next = 1'b1;
      end
      hfall = hour_button_high && !item.hour_button_level;
      if (hfall) begin
        hour_button_high_next = 1'b0;
        update_next           = 1'b1;
        hour_count_next       = (hour_count_next + 5'd1 >= HoursPerDay) ? '0 :
                                hour_count_next + 5'd1;
      end else begin
        if (!hour_button_high && item.hour_button_level) begin
          hour_button_high_next = 1'b1;
        end
        sfall = second_button_high && !item.second_button_level;
        if (sfall) begin
          second_button_high_next = 1'b0;
          update_next             = 1'b1;
          second_count_next       = '0;
          last_second_ms_next     = item.now_ms;
          dot_flag_next           = 1'b0;
        end else if (!second_button_high && item.second_button_level) begin
          second_button_high_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_count         <= '0;
      minute_count       <= '0;
      second_count       <= '0;
      dot_flag           <= 1'b0;
      minute_button_high <= 1'b0;
      hour_button_high   <= 1'b0;
      second_button_high <= 1'b0;
      last_second_ms     <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= item_valid;
      end
      if (fire) begin
        hour_count         <= hour_count_next;
        minute_count       <= minute_count_next;
        second_count       <= second_count_next;
        dot_flag           <= dot_flag_next;
        minute_button_high <= minute_button_high_next;
        hour_button_high   <= hour_button_high_next;
        second_button_high <= second_button_high_next;
        last_second_ms     <= last_second_ms_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.hours          <= hour_count_next;
      result.minutes        <= minute_count_next;
      result.seconds        <= second_count_next;
      result.dot_on         <= dot_flag_next;
      result.display_update <= update_next;
    end
  end

  a_time_in_range: assert property (@(posedge clk) disable iff (rst)
    (hour_count < HoursPerDay) && (minute_count < MinsPerHour) &&
    (second_count < SecsPerMin))
    else $error("time counter out of range");

  a_state_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(hour_count) && $stable(minute_count) &&
              $stable(second_count) && $stable(last_second_ms))
    else $error("time state changed without a request");

  a_no_update_no_change: assert property (@(posedge clk) disable iff (rst)
    fire && !update_next |=> $stable(hour_count) && $stable(minute_count) &&
                             $stable(second_count) && $stable(dot_flag))
    else $error("time changed on a pass flagged as no update");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    fire |=> (result.hours == hour_count) && (result.minutes == minute_count) &&
             (result.seconds == second_count) && (result.dot_on == dot_flag))
    else $error("result register disagrees with time state");

endmodule

// ===== design/time_of_day_clock_with_set_buttons.sv =====
// Top level of the time-of-day clock: tick period register, input register
// and time keeping core. Depends on tod_pkg, tod_in_stage and tod_core.
//
// Usage:
//   Each input request is one polling pass: a free-running millisecond stamp
//   now_ms and the three button pin levels (0 when pressed). Every request
//   gives exactly one result: hours, minutes, seconds, dot_on and a
//   display_update flag that is 1 when the dot, the tick or a button changed anything.
//   A request is taken at a clock edge with in_valid high and in_stall low;
//   a result is taken with out_valid high and out_stall low.
//   out_valid rises once an accepted request has passed the input register,
//   then the result register; one request per cycle is sustained while
//   out_stall is low, as the core handles each request in a single pass.
//   When the receiver stalls, the result holds; in_stall rises as soon as the
//   input register holds a request that cannot move on; nothing is dropped.
//   tick_period_ms is written with cfg_write/cfg_data while no request is in
//   flight. Reset (rst, synchronous) zeroes the time, dot and button state
//   and sets the period to 1000 ms.
module time_of_day_clock_with_set_buttons (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tod_pkg::PeriodWidth-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tod_pkg::MsWidth-1:0]     now_ms,
  input  logic                            minute_button_level,
  input  logic                            hour_button_level,
  input  logic                            second_button_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tod_pkg::HourWidth-1:0]   hours,
  output logic [tod_pkg::MinWidth-1:0]    minutes,
  output logic [tod_pkg::SecWidth-1:0]    seconds,
  output logic                            dot_on,
  output logic                            display_update
);
  import tod_pkg::*;

  logic [PeriodWidth-1:0] tick_period_ms;
  tod_item_t              in_item;
  tod_item_t              item;
  logic                   item_valid;
  logic                   advance;
  tod_result_t            result;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period_ms <= PeriodDefault;
    end else if (cfg_write) begin
      tick_period_ms <= cfg_data;
    end
  end

  assign in_item.now_ms              = now_ms;
  assign in_item.minute_button_level = minute_button_level;
  assign in_item.hour_button_level   = hour_button_level;
  assign in_item.second_button_level = second_button_level;

  tod_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tod_core u_core (
    .clk            (clk),
    .rst            (rst),
    .tick_period_ms (tick_period_ms),
    .item_valid     (item_valid),
    .item           (item),
    .advance        (advance),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result         (result)
  );

  assign hours          = result.hours;
  assign minutes        = result.minutes;
  assign seconds        = result.seconds;
  assign dot_on         = result.dot_on;
  assign display_update = result.display_update;

endmodule

// ===== verif/tb_time_of_day_clock_with_set_buttons.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for time_of_day_clock_with_set_buttons: directed table,
// then random polling requests under random stalls. Depends on tod_pkg and the RTL.
module tb_time_of_day_clock_with_set_buttons;
  import tod_pkg::*;

  typedef struct packed {
    logic [MsWidth-1:0] now;
    logic               m;
    logic               h;
    logic               s;
    logic               typed;
    tod_result_t        want;
  } dir_row_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [PeriodWidth-1:0] cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [MsWidth-1:0]     now_ms = '0;
  logic                   minute_button_level = 1'b0;
  logic                   hour_button_level = 1'b0;
  logic                   second_button_level = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [HourWidth-1:0]   hours;
  logic [MinWidth-1:0]    minutes;
  logic [SecWidth-1:0]    seconds;
  logic                   dot_on;
  logic                   display_update;

  // Predicted clock state
  logic [PeriodWidth-1:0] period_ms = PeriodDefault;
  logic [HourWidth-1:0]   cur_hour = '0;
  logic [MinWidth-1:0]    cur_min = '0;
  logic [SecWidth-1:0]    cur_sec = '0;
  logic                   cur_dot = 1'b0;
  logic                   min_btn_up = 1'b0;
  logic                   hour_btn_up = 1'b0;
  logic                   sec_btn_up = 1'b0;
  logic [MsWidth-1:0]     last_tick_ms = '0;

  tod_result_t   expected_times[$];
  dir_row_t      dir_rows[$];
  logic [31:0]   clock_ms = '0;
  int            mismatch_count = 0;
  bit            sender_idle_on = 1'b1;
  bit            recv_idle_on = 1'b1;
  bit            hold_request = 1'b0;

  time_of_day_clock_with_set_buttons u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write           (cfg_write),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .now_ms              (now_ms),
    .minute_button_level (minute_button_level),
    .hour_button_level   (hour_button_level),
    .second_button_level (second_button_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .hours               (hours),
    .minutes             (minutes),
    .seconds             (seconds),
    .dot_on              (dot_on),
    .display_update      (display_update)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void add_hour();
    if (cur_hour == HoursPerDay - 5'd1) cur_hour = '0;
    else cur_hour = cur_hour + 5'd1;
  endfunction

  function automatic void add_minute();
    if (cur_min == MinsPerHour - 6'd1) begin
      cur_min = '0;
      add_hour();
    end else begin
      cur_min = cur_min + 6'd1;
    end
  endfunction

  // One polling pass: tick first, then at most one button falling edge.
  function automatic tod_result_t advance_time_of_day(input tod_item_t req);
    logic [MsWidth-1:0] half_at;
    logic [MsWidth-1:0] full_at;
    logic               upd;
    tod_result_t        res;
    half_at = last_tick_ms + {17'd0, period_ms[15:1]};
    full_at = last_tick_ms + {16'd0, period_ms};
    upd = 1'b0;
    if (!cur_dot && req.now_ms > half_at) begin
      cur_dot = 1'b1;
      upd = 1'b1;
    end
    if (req.now_ms > full_at) begin
      if (cur_sec == SecsPerMin - 6'd1) begin
        cur_sec = '0;
        add_minute();
      end else begin
        cur_sec = cur_sec + 6'd1;
      end
      last_tick_ms = req.now_ms;
      cur_dot = 1'b0;
      upd = 1'b1;
    end
    if (min_btn_up && !req.minute_button_level) begin
      min_btn_up = 1'b0;
      add_minute();
      upd = 1'b1;
    end else begin
      if (req.minute_button_level) min_btn_up = 1'b1;
      if (hour_btn_up && !req.hour_button_level) begin
        hour_btn_up = 1'b0;
        add_hour();
        upd = 1'b1;
      end else begin
        if (req.hour_button_level) hour_btn_up = 1'b1;
        if (sec_btn_up && !req.second_button_level) begin
          sec_btn_up = 1'b0;
          cur_sec = '0;
          last_tick_ms = req.now_ms;
          cur_dot = 1'b0;
          upd = 1'b1;
        end else if (req.second_button_level) begin
          sec_btn_up = 1'b1;
        end
      end
    end
    res.hours = cur_hour;
    res.minutes = cur_min;
    res.seconds = cur_sec;
    res.dot_on = cur_dot;
    res.display_update = upd;
    return res;
  endfunction

  function automatic void add_row(input logic [31:0] now, input logic m, input logic h,
                                  input logic s, input logic typed, input int hh,
                                  input int mm, input int ss, input logic dot,
                                  input logic upd);
    dir_row_t row;
    row.now = now;
    row.m = m;
    row.h = h;
    row.s = s;
    row.typed = typed;
    row.want.hours = 5'(hh);
    row.want.minutes = 6'(mm);
    row.want.seconds = 6'(ss);
    row.want.dot_on = dot;
    row.want.display_update = upd;
    dir_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Offer one request, hold it until accepted, then queue its expected result.
  task automatic send_request(input logic [31:0] now, input logic m, input logic h,
                              input logic s, input logic typed, input tod_result_t typed_res);
    tod_item_t   req;
    tod_result_t predicted;
    int          gap;
    req.now_ms = now;
    req.minute_button_level = m;
    req.hour_button_level = h;
    req.second_button_level = s;
    gap = 0;
    if (sender_idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    now_ms <= now;
    minute_button_level <= m;
    hour_button_level <= h;
    second_button_level <= s;
    do @(posedge clk); while (in_stall);
    predicted = advance_time_of_day(req);
    expected_times.push_back(typed ? typed_res : predicted);
  endtask

  task automatic offer(input logic [31:0] now, input logic m, input logic h, input logic s);
    send_request(now, m, h, s, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_times.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(input logic [PeriodWidth-1:0] p);
    cfg_write <= 1'b1;
    cfg_data <= p;
    @(posedge clk);
    cfg_write <= 1'b0;
    period_ms = p;
  endtask

  // Steer to 23:59 with button presses, then tick through midnight.
  task automatic roll_over_day();
    offer(clock_ms, 1'b1, 1'b1, 1'b1);
    while (cur_min != MinsPerHour - 6'd1) begin
      offer(clock_ms, 1'b0, 1'b1, 1'b1);
      offer(clock_ms, 1'b1, 1'b1, 1'b1);
    end
    while (cur_hour != HoursPerDay - 5'd1) begin
      offer(clock_ms, 1'b1, 1'b0, 1'b1);
      offer(clock_ms, 1'b1, 1'b1, 1'b1);
    end
    repeat (61) begin
      clock_ms = clock_ms + {16'd0, period_ms} + 32'd1;
      offer(clock_ms, 1'b1, 1'b1, 1'b1);
    end
  endtask

  task automatic send_polling_burst(input int count);
    int          mode;
    int          burst_left;
    int          pick;
    logic [31:0] half_off;
    logic [31:0] full_off;
    logic        m;
    logic        h;
    logic        s;
    mode = 0;
    burst_left = 0;
    repeat (count) begin
      if (burst_left == 0) begin
        mode = $urandom_range(0, 2);
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      half_off = {17'd0, period_ms[15:1]};
      full_off = {16'd0, period_ms};
      pick = $urandom_range(0, 63);
      if (pick == 0) begin
        clock_ms = $urandom;
      end else if (pick == 1) begin
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, int'(period_ms));
      end else if (pick < 10) begin
        // aim at the compare boundaries, this also recovers from backward jumps
        case ($urandom_range(0, 3))
          0: clock_ms = last_tick_ms + half_off;
          1: clock_ms = last_tick_ms + half_off + 32'd1;
          2: clock_ms = last_tick_ms + full_off;
          default: clock_ms = last_tick_ms + full_off + 32'd1;
        endcase
      end else begin
        clock_ms = clock_ms + $urandom_range(0, int'(period_ms) + 1);
      end
      case (mode)
        0: {m, h, s} = 3'b111;
        1: begin
          m = ($urandom_range(0, 3) != 0);
          h = ($urandom_range(0, 3) != 0);
          s = ($urandom_range(0, 3) != 0);
        end
        default: {m, h, s} = 3'($urandom);
      endcase
      offer(clock_ms, m, h, s);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left = 150;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    tod_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (expected_times.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = expected_times.pop_front();
          check_field("hours", 32'(hours), 32'(want.hours));
          check_field("minutes", 32'(minutes), 32'(want.minutes));
          check_field("seconds", 32'(seconds), 32'(want.seconds));
          check_field("dot_on", 32'(dot_on), 32'(want.dot_on));
          check_field("display_update", 32'(display_update), 32'(want.display_update));
        end
      end
    end
  end

  initial begin
    logic [PeriodWidth-1:0] p;
    //       now            m  h  s  typed hh mm ss dot upd
    add_row(32'd0,          0, 0, 0, 1,    0, 0, 0, 0, 0);
    add_row(32'd0,          1, 1, 1, 1,    0, 0, 0, 0, 0);
    add_row(32'd501,        1, 1, 1, 1,    0, 0, 0, 1, 1);
    add_row(32'd1001,       1, 1, 1, 1,    0, 0, 1, 0, 1);
    add_row(32'd1001,       0, 1, 1, 1,    0, 1, 1, 0, 1);
    add_row(32'd1001,       1, 0, 1, 1,    1, 1, 1, 0, 1);
    add_row(32'd1001,       0, 0, 0, 1,    1, 2, 1, 0, 1);
    add_row(32'd1001,       0, 0, 0, 1,    1, 2, 0, 0, 1);
    add_row(32'hFFFF_FFFF,  0, 0, 0, 1,    1, 2, 1, 0, 1);
    add_row(32'd0,          0, 0, 0, 1,    1, 2, 1, 0, 0);
    add_row(32'd500,        0, 0, 0, 1,    1, 2, 1, 1, 1);
    add_row(32'd1000,       0, 0, 0, 1,    1, 2, 2, 0, 1);
    add_row(32'd2000,       0, 0, 0, 1,    1, 2, 2, 1, 1);
    add_row(32'd2001,       1, 1, 1, 1,    1, 2, 3, 0, 1);
    // tick and seconds reset in one pass, then priority between the buttons
    add_row(32'd3002,       1, 1, 0, 0,    0, 0, 0, 0, 0);
    add_row(32'd3002,       0, 0, 0, 0,    0, 0, 0, 0, 0);
    add_row(32'd3002,       1, 0, 1, 0,    0, 0, 0, 0, 0);
    add_row(32'd3002,       1, 1, 1, 0,    0, 0, 0, 0, 0);
    add_row(32'd3002,       1, 0, 0, 0,    0, 0, 0, 0, 0);
    add_row(32'd3002,       1, 1, 0, 0,    0, 0, 0, 0, 0);
    add_row(32'h7FFF_FFFF,  1, 1, 1, 0,    0, 0, 0, 0, 0);
    add_row(32'h8000_0000,  1, 1, 1, 0,    0, 0, 0, 0, 0);
    add_row(32'h8000_01F5,  1, 1, 1, 0,    0, 0, 0, 0, 0);
    add_row(32'h8000_03E9,  1, 1, 1, 0,    0, 0, 0, 0, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_request(dir_rows[i].now, dir_rows[i].m, dir_rows[i].h, dir_rows[i].s,
                   dir_rows[i].typed, dir_rows[i].want);
    clock_ms = 32'h8000_03E9;
    drain();

    for (int k = 0; k < 7; k++) begin
      case (k)
        0: p = 16'hFFFF;
        1: p = 16'd2;
        2: p = 16'd0;
        3: p = 16'd1;
        4: p = PeriodDefault;
        5: p = 16'($urandom_range(2, 65535));
        default: p = 16'($urandom_range(3, 40));
      endcase
      sender_idle_on = (k % 3 != 1);
      recv_idle_on = (k % 3 != 2);
      write_period(p);
      if (k == 1) roll_over_day();
      send_polling_burst(170);
      drain();
    end

    // Hold the result side long enough that the block backs up into in_stall.
    sender_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    write_period(16'd7);
    hold_request = 1'b1;
    send_polling_burst(60);
    drain();

    write_period(16'($urandom_range(2, 2000)));
    send_polling_burst(150);
    drain();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tod_pkg.sv
design/tod_in_stage.sv
design/tod_core.sv
design/time_of_day_clock_with_set_buttons.sv
verif/tb_time_of_day_clock_with_set_buttons.sv
